>>> sv/otlv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otlv_pkg
// Types, codes and small lookup functions shared by the TLV EEPROM parser.
// ----------------------------------------------------------------------------
package otlv_pkg;

  // Parser phases.
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_TYPE   = 3'd1;
  localparam logic [2:0] PH_LEN    = 3'd2;
  localparam logic [2:0] PH_VALUE  = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  // Event kinds.
  localparam logic [2:0] EV_VALUE  = 3'd0;
  localparam logic [2:0] EV_EMPTY  = 3'd1;
  localparam logic [2:0] EV_BADHDR = 3'd2;
  localparam logic [2:0] EV_SHORT  = 3'd3;
  localparam logic [2:0] EV_CRC    = 3'd4;
  localparam logic [2:0] EV_REGION = 3'd5;
  localparam logic [2:0] EV_TRUNC  = 3'd6;

  // Record type codes.
  localparam logic [7:0] TYPE_PRODUCT = 8'h21;
  localparam logic [7:0] TYPE_PART    = 8'h22;
  localparam logic [7:0] TYPE_SERIAL  = 8'h23;
  localparam logic [7:0] TYPE_DATE    = 8'h25;
  localparam logic [7:0] TYPE_VERSION = 8'h26;
  localparam logic [7:0] TYPE_MFR     = 8'h2B;
  localparam logic [7:0] TYPE_MODEL   = 8'h2E;
  localparam logic [7:0] TYPE_CRC     = 8'hFE;

  // Field codes.
  localparam logic [2:0] FLD_PRODUCT = 3'd0;
  localparam logic [2:0] FLD_PART    = 3'd1;
  localparam logic [2:0] FLD_SERIAL  = 3'd2;
  localparam logic [2:0] FLD_DATE    = 3'd3;
  localparam logic [2:0] FLD_VERSION = 3'd4;
  localparam logic [2:0] FLD_MFR     = 3'd5;
  localparam logic [2:0] FLD_MODEL   = 3'd6;

  localparam logic [16:0] HEADER_BYTES = 17'd11;
  localparam logic [15:0] IMAGE_SIZE_RESET = 16'd256;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] code;
    logic [7:0] value;
    logic       last;
  } result_t;

  // Results of one parsed byte: how many (0..2) and the words in order.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  typedef struct packed {
    logic       known;
    logic [2:0] code;
  } field_t;

  typedef struct packed {
    logic       stop;
    logic [2:0] kind;
  } rec_end_t;

  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h54;
      3'd1:    b = 8'h6C;
      3'd2:    b = 8'h76;
      3'd3:    b = 8'h49;
      3'd4:    b = 8'h6E;
      3'd5:    b = 8'h66;
      3'd6:    b = 8'h6F;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic field_t field_of(input logic [7:0] t);
    field_t f;
    f.known = 1'b1;
    case (t)
      TYPE_PRODUCT: f.code = FLD_PRODUCT;
      TYPE_PART:    f.code = FLD_PART;
      TYPE_SERIAL:  f.code = FLD_SERIAL;
      TYPE_DATE:    f.code = FLD_DATE;
      TYPE_VERSION: f.code = FLD_VERSION;
      TYPE_MFR:     f.code = FLD_MFR;
      TYPE_MODEL:   f.code = FLD_MODEL;
      default: begin
        f.known = 1'b0;
        f.code  = FLD_PRODUCT;
      end
    endcase
    return f;
  endfunction

  // Decides what follows when the next record would start at q.
  function automatic rec_end_t record_end(input logic [16:0] q, input logic [15:0] size,
                                          input logic [15:0] region);
    rec_end_t   r;
    logic [16:0] limit;
    limit = HEADER_BYTES + {1'b0, region};
    r.stop = 1'b0;
    r.kind = EV_REGION;
    if (q >= {1'b0, size} || q >= limit) begin
      r.stop = 1'b1;
    end else if (q + 17'd2 > {1'b0, size}) begin
      r.stop = 1'b1;
      r.kind = EV_TRUNC;
    end
    return r;
  endfunction

endpackage

>>> sv/otlv_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otlv_parse
// Input register and per-byte parse logic with the parser state registers.
// ----------------------------------------------------------------------------
module otlv_parse (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_take,
  input  logic [7:0]            data_byte,
  input  logic                  image_start,
  input  logic [15:0]           image_size,
  output otlv_pkg::push_t       push
);

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_start;

  logic [15:0] byte_position, byte_position_next;
  logic [2:0]  parse_phase, parse_phase_next;
  logic [15:0] region_length, region_length_next;
  logic [7:0]  record_type, record_type_next;
  logic [7:0]  value_remaining, value_remaining_next;
  logic        signature_ok, signature_ok_next;

  logic [15:0] eff_pos;
  logic [2:0]  eff_phase;
  logic [15:0] eff_region;
  logic [7:0]  eff_type;
  logic [7:0]  eff_rem;
  logic        eff_sig;
  logic [16:0] q;
  logic [7:0]  rem_dec;
  otlv_pkg::field_t   fld;
  otlv_pkg::rec_end_t rend;
  otlv_pkg::result_t  main_res;
  otlv_pkg::result_t  end_res;
  logic        main_vld;
  logic        end_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_take;
    end
    if (in_take) begin
      s1_byte  <= data_byte;
      s1_start <= image_start;
    end
  end

  always_comb begin
    // A start flag clears the state before the byte is parsed.
    eff_pos    = s1_start ? 16'd0 : byte_position;
    eff_phase  = s1_start ? otlv_pkg::PH_HEADER : parse_phase;
    eff_region = s1_start ? 16'd0 : region_length;
    eff_type   = s1_start ? 8'd0 : record_type;
    eff_rem    = s1_start ? 8'd0 : value_remaining;
    eff_sig    = s1_start ? 1'b1 : signature_ok;

    byte_position_next   = eff_pos;
    parse_phase_next     = eff_phase;
    region_length_next   = eff_region;
    record_type_next     = eff_type;
    value_remaining_next = eff_rem;
    signature_ok_next    = eff_sig;

    q        = {1'b0, eff_pos} + 17'd1;
    rem_dec  = (eff_rem != 8'd0) ? eff_rem - 8'd1 : 8'd0;
    fld      = otlv_pkg::field_of(eff_type);
    rend     = otlv_pkg::record_end(q, image_size, eff_region);

    main_vld = 1'b0;
    end_vld  = 1'b0;
    main_res = '{kind: otlv_pkg::EV_VALUE, code: fld.code, value: s1_byte,
                 last: (eff_rem == 8'd1)};
    end_res  = '{kind: rend.kind, code: otlv_pkg::FLD_PRODUCT, value: 8'd0, last: 1'b0};

    if (eff_phase < otlv_pkg::PH_DONE) begin
      if (eff_pos != 16'hFFFF) begin
        byte_position_next = eff_pos + 16'd1;
      end
      case (eff_phase)
        otlv_pkg::PH_HEADER: begin
          if (eff_pos == 16'd0 && image_size < 16'd11) begin
            parse_phase_next = otlv_pkg::PH_DONE;
            end_vld          = 1'b1;
            end_res.kind     = otlv_pkg::EV_SHORT;
          end else if (eff_pos < 16'd8) begin
            signature_ok_next = eff_sig & (s1_byte == otlv_pkg::sig_byte(eff_pos[2:0]));
            if (eff_pos == 16'd7 && !signature_ok_next) begin
              parse_phase_next = otlv_pkg::PH_DONE;
              end_vld          = 1'b1;
              end_res.kind     = otlv_pkg::EV_BADHDR;
            end
          end else if (eff_pos == 16'd9) begin
            region_length_next = {s1_byte, 8'd0};
          end else if (eff_pos == 16'd10) begin
            region_length_next = eff_region | {8'd0, s1_byte};
            // The walk test uses the completed total length.
            rend = otlv_pkg::record_end(q, image_size, region_length_next);
            end_res.kind     = rend.kind;
            end_vld          = rend.stop;
            parse_phase_next = rend.stop ? otlv_pkg::PH_DONE : otlv_pkg::PH_TYPE;
          end
        end
        otlv_pkg::PH_TYPE: begin
          record_type_next = s1_byte;
          parse_phase_next = otlv_pkg::PH_LEN;
        end
        otlv_pkg::PH_LEN: begin
          if (q + {9'd0, s1_byte} > {1'b0, image_size}) begin
            parse_phase_next = otlv_pkg::PH_DONE;
            end_vld          = 1'b1;
            end_res.kind     = otlv_pkg::EV_TRUNC;
          end else if (eff_type == otlv_pkg::TYPE_CRC) begin
            parse_phase_next = otlv_pkg::PH_DONE;
            end_vld          = 1'b1;
            end_res.kind     = otlv_pkg::EV_CRC;
          end else if (s1_byte == 8'd0) begin
            main_vld         = fld.known;
            main_res.kind    = otlv_pkg::EV_EMPTY;
            main_res.value   = 8'd0;
            main_res.last    = 1'b0;
            end_vld          = rend.stop;
            parse_phase_next = rend.stop ? otlv_pkg::PH_DONE : otlv_pkg::PH_TYPE;
          end else begin
            value_remaining_next = s1_byte;
            parse_phase_next     = otlv_pkg::PH_VALUE;
          end
        end
        otlv_pkg::PH_VALUE: begin
          main_vld             = fld.known;
          value_remaining_next = rem_dec;
          if (rem_dec == 8'd0) begin
            end_vld          = rend.stop;
            parse_phase_next = rend.stop ? otlv_pkg::PH_DONE : otlv_pkg::PH_TYPE;
          end
        end
        default: begin
        end
      endcase
    end

    push.count  = 2'd0;
    push.first  = end_res;
    push.second = end_res;
    if (s1_valid) begin
      if (main_vld) begin
        push.first = main_res;
        push.count = end_vld ? 2'd2 : 2'd1;
      end else if (end_vld) begin
        push.count = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= 16'd0;
      parse_phase     <= otlv_pkg::PH_HEADER;
      region_length   <= 16'd0;
      record_type     <= 8'd0;
      value_remaining <= 8'd0;
      signature_ok    <= 1'b1;
    end else if (s1_valid) begin
      byte_position   <= byte_position_next;
      parse_phase     <= parse_phase_next;
      region_length   <= region_length_next;
      record_type     <= record_type_next;
      value_remaining <= value_remaining_next;
      signature_ok    <= signature_ok_next;
    end
  end

  // Two words from one byte are always a value or empty word then an end word.
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |-> (push.first.kind == otlv_pkg::EV_VALUE ||
                            push.first.kind == otlv_pkg::EV_EMPTY) &&
                           (push.second.kind == otlv_pkg::EV_REGION ||
                            push.second.kind == otlv_pkg::EV_TRUNC))
    else $error("otlv_parse: bad result pair");

  // Once done, the parser stays silent until a new start flag arrives.
  a_done_quiet: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_start && parse_phase == otlv_pkg::PH_DONE |-> push.count == 2'd0)
    else $error("otlv_parse: result after end of image");

endmodule

>>> sv/otlv_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otlv_fifo
// Result queue that takes up to two words per cycle and gives one per cycle.
// ----------------------------------------------------------------------------
module otlv_fifo #(
  parameter int DEPTH = 8   // power of two, at least 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  otlv_pkg::push_t              push,
  input  logic                         pop,
  output logic                         not_empty,
  output otlv_pkg::result_t            head,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  otlv_pkg::result_t mem [DEPTH];
  logic [PTR_W-1:0]  wptr;
  logic [PTR_W-1:0]  rptr;
  logic [PTR_W-1:0]  wptr_inc;
  logic              do_pop;

  assign wptr_inc  = wptr + PTR_W'(1);
  assign not_empty = (count != CNT_W'(0));
  assign head      = mem[rptr];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wptr_inc] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + PTR_W'(push.count);
      if (do_pop) begin
        rptr <= rptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push.count) - CNT_W'(do_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> ({1'b0, count} + (CNT_W + 1)'(push.count) - (CNT_W + 1)'(do_pop))
                           <= (CNT_W + 1)'(DEPTH))
    else $error("otlv_fifo: result queue overflow");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    do_pop && count == CNT_W'(1) && push.count == 2'd0 |=> !not_empty)
    else $error("otlv_fifo: queue not empty after last word taken");

endmodule

>>> sv/onie_tlv_eeprom_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onie_tlv_eeprom_parser_core
// Parses a TLV EEPROM image one byte per word and emits tagged field bytes
// and end-of-image events.
//
//   Channel  Direction  Handshake                 Word
//   in       input      in_valid / in_ready       data_byte, image_start
//   out      output     out_valid / out_ready     event_kind, field_code,
//                                                 value_byte, value_last
//   cfg      input      cfg_write_en              cfg_write_data (image_size)
//
// One input word is taken per cycle while in_ready is high; its results pass
// through the input register and the parse logic into the result queue.
// A byte that ends a record can give two result words; the queue drains one
// per cycle while out_ready is set; in_ready drops while over RESULT_DEPTH-4
// words wait. Reset clears the parser and the queue, and image_size to 256.
// ----------------------------------------------------------------------------
module onie_tlv_eeprom_parser_core #(
  parameter int RESULT_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        image_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  event_kind,
  output logic [2:0]  field_code,
  output logic [7:0]  value_byte,
  output logic        value_last,
  input  logic        cfg_write_en,
  input  logic [15:0] cfg_write_data
);

  localparam int CNT_W = $clog2(RESULT_DEPTH + 1);
  localparam logic [CNT_W-1:0] READY_MAX = CNT_W'(RESULT_DEPTH - 4);

  logic [15:0]       image_size;
  logic              in_take;
  otlv_pkg::push_t   push;
  otlv_pkg::result_t head;
  logic [CNT_W-1:0]  count;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_size <= otlv_pkg::IMAGE_SIZE_RESET;
    end else if (cfg_write_en) begin
      image_size <= cfg_write_data;
    end
  end

  // Room is kept for two words from the byte in flight and two from this one.
  assign in_ready = (count <= READY_MAX);
  assign in_take  = in_valid && in_ready;

  otlv_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .in_take     (in_take),
    .data_byte   (data_byte),
    .image_start (image_start),
    .image_size  (image_size),
    .push        (push)
  );

  otlv_fifo #(
    .DEPTH (RESULT_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (out_ready),
    .not_empty (out_valid),
    .head      (head),
    .count     (count)
  );

  assign event_kind = head.kind;
  assign field_code = head.code;
  assign value_byte = head.value;
  assign value_last = head.last;

endmodule
